/* rtl/core/ppgf_pkg.sv */
// Shared types, constants and the microprogram of the PPG filter and LED gain block.
`default_nettype none
package ppgf_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COEF_FRAC_DEF   = 15;
	localparam int NUM_CH          = 3;
	localparam int LED_W           = 8;
	localparam int MODE_W          = 2;
	localparam int CFG_IDX_W       = 3;
	localparam int UPC_W           = 4;
	localparam int CH_W            = 2;

	// Filter coefficients in millionths.
	localparam longint HP_A0_U = 881600;
	localparam longint HP_A1_U = 940800;
	localparam longint HP_A2_U = 940800;
	localparam longint LP_A0_U = 591400;
	localparam longint LP_A1_U = 204300;
	localparam longint LP_A2_U = 204300;
	localparam longint UL_A0_U = 987500;
	localparam longint UL_A1_U = 6244;
	localparam longint UL_A2_U = 6244;

	localparam logic [MODE_W-1:0] MODE_RED    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RED_IR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ALL    = 2'd2;

	localparam logic [CH_W-1:0] CH_RED   = 2'd0;
	localparam logic [CH_W-1:0] CH_IR    = 2'd1;
	localparam logic [CH_W-1:0] CH_GREEN = 2'd2;

	localparam logic [1:0] STG_HP = 2'd0;
	localparam logic [1:0] STG_LP = 2'd1;
	localparam logic [1:0] STG_UL = 2'd2;

	localparam logic [UPC_W-1:0] FIN_PC = 4'd15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE  = 3'd0,
		REG_HIGH  = 3'd1,
		REG_LOW   = 3'd2,
		REG_OFF   = 3'd3,
		REG_STBY  = 3'd4,
		REG_MAXC  = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} run_st_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_PROX,
		KIND_DATA
	} kind_t;

	typedef enum logic [1:0] {
		OPND_Y,
		OPND_X,
		OPND_XP
	} opnd_t;

	typedef enum logic [1:0] {
		ACC_NOP,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [1:0] {
		BR_NEXT,
		BR_CHAN,
		BR_DONE
	} br_t;

	typedef struct packed {
		opnd_t      opnd;
		logic [1:0] stg;
		logic [1:0] cix;
		acc_op_t    acc_op;
		logic       wb;
		br_t        br;
	} ucw_t;

	// round(c * 2^frac) from a coefficient given in millionths.
	function automatic longint qcoef(longint micro, int frac);
		return ((micro <<< frac) + 64'sd500000) / 64'sd1000000;
	endfunction

	function automatic ucw_t uw(opnd_t o, logic [1:0] s, logic [1:0] c, acc_op_t a,
		logic w, br_t b);
		ucw_t r;
		r.opnd   = o;
		r.stg    = s;
		r.cix    = c;
		r.acc_op = a;
		r.wb     = w;
		r.br     = b;
		return r;
	endfunction

	// One channel takes five words per filter stage: three products, the last
	// accumulation, and the clamped write-back. The product register sits between
	// the multiplier and the accumulator, so each accumulation trails its product.
	function automatic ucw_t ucode(logic [UPC_W-1:0] pc);
		ucw_t r;
		case (pc)
			4'd0:  r = uw(OPND_Y,  STG_HP, 2'd0, ACC_NOP,  1'b0, BR_NEXT);
			4'd1:  r = uw(OPND_X,  STG_HP, 2'd1, ACC_LOAD, 1'b0, BR_NEXT);
			4'd2:  r = uw(OPND_XP, STG_HP, 2'd2, ACC_ADD,  1'b0, BR_NEXT);
			4'd3:  r = uw(OPND_Y,  STG_HP, 2'd0, ACC_SUB,  1'b0, BR_NEXT);
			4'd4:  r = uw(OPND_Y,  STG_HP, 2'd0, ACC_NOP,  1'b1, BR_NEXT);
			4'd5:  r = uw(OPND_Y,  STG_LP, 2'd0, ACC_NOP,  1'b0, BR_NEXT);
			4'd6:  r = uw(OPND_X,  STG_LP, 2'd1, ACC_LOAD, 1'b0, BR_NEXT);
			4'd7:  r = uw(OPND_XP, STG_LP, 2'd2, ACC_ADD,  1'b0, BR_NEXT);
			4'd8:  r = uw(OPND_Y,  STG_LP, 2'd0, ACC_ADD,  1'b0, BR_NEXT);
			4'd9:  r = uw(OPND_Y,  STG_LP, 2'd0, ACC_NOP,  1'b1, BR_NEXT);
			4'd10: r = uw(OPND_Y,  STG_UL, 2'd0, ACC_NOP,  1'b0, BR_NEXT);
			4'd11: r = uw(OPND_X,  STG_UL, 2'd1, ACC_LOAD, 1'b0, BR_NEXT);
			4'd12: r = uw(OPND_XP, STG_UL, 2'd2, ACC_ADD,  1'b0, BR_NEXT);
			4'd13: r = uw(OPND_Y,  STG_UL, 2'd0, ACC_ADD,  1'b0, BR_NEXT);
			4'd14: r = uw(OPND_Y,  STG_UL, 2'd0, ACC_NOP,  1'b1, BR_CHAN);
			4'd15: r = uw(OPND_Y,  STG_HP, 2'd0, ACC_NOP,  1'b0, BR_DONE);
			default: r = uw(OPND_Y, STG_HP, 2'd0, ACC_NOP, 1'b0, BR_DONE);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/ppgf_mac.sv */
// Shared multiply-accumulate unit with the clamp of one first-order filter stage.
`default_nettype none
module ppgf_mac #(
	parameter int SAMPLE_BITS    = ppgf_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = ppgf_pkg::COEF_FRAC_DEF
) (
	input  logic                          clk,
	input  logic [SAMPLE_BITS-1:0]        opnd,
	input  logic [COEF_FRAC_BITS:0]       coef,
	input  ppgf_pkg::acc_op_t             acc_op,
	output logic [SAMPLE_BITS-1:0]        result
);
	import ppgf_pkg::*;

	localparam int COEF_W = COEF_FRAC_BITS + 1;
	localparam int PROD_W = SAMPLE_BITS + COEF_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int HI_W   = ACC_W - 1 - COEF_FRAC_BITS;

	logic [PROD_W-1:0]       prod_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] prod_ext;
	logic [HI_W-1:0]         hi;

	assign prod_ext = $signed({2'b00, prod_s1});

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(opnd) * PROD_W'(coef);
		case (acc_op)
			ACC_LOAD: acc_q <= prod_ext;
			ACC_ADD:  acc_q <= acc_q + prod_ext;
			ACC_SUB:  acc_q <= acc_q - prod_ext;
			default:  acc_q <= acc_q;
		endcase
	end

	// Negative sums give zero; the truncated quotient saturates at full scale.
	assign hi = acc_q[ACC_W-2:COEF_FRAC_BITS];

	always_comb begin
		if (acc_q[ACC_W-1]) begin
			result = '0;
		end else if (|hi[HI_W-1:SAMPLE_BITS]) begin
			result = '1;
		end else begin
			result = hi[SAMPLE_BITS-1:0];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/ppg_filter_and_led_gain.sv */
// Top level of the PPG filter cascade and LED automatic gain block.
// Each accepted request is one sensor event. A data-ready event runs every enabled
// channel through high-pass, low-pass and very-low-pass stages on one shared
// multiplier under a 16-word microprogram whose last word makes the gain decision;
// the next request is taken once the block has returned to idle. A proximity event
// or an event with no flag goes straight to the gain decision. Each enabled channel
// takes nine products through the single multiplier. The gain decision waits while
// a stalled result still holds the output register. A finished result waits in the
// output register while the next request is taken.
// Configuration writes are always ready and are to be made while the block is idle.
`default_nettype none
module ppg_filter_and_led_gain #(
	parameter int SAMPLE_BITS    = ppgf_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = ppgf_pkg::COEF_FRAC_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              prox_event,
	input  logic                              data_ready,
	input  logic [SAMPLE_BITS-1:0]            red_sample,
	input  logic [SAMPLE_BITS-1:0]            ir_sample,
	input  logic [SAMPLE_BITS-1:0]            green_sample,
	input  logic [ppgf_pkg::LED_W-1:0]        led_amplitude,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              status,
	output logic [SAMPLE_BITS-1:0]            red_band,
	output logic [SAMPLE_BITS-1:0]            red_baseline,
	output logic [SAMPLE_BITS-1:0]            ir_band,
	output logic [SAMPLE_BITS-1:0]            ir_baseline,
	output logic [SAMPLE_BITS-1:0]            green_band,
	output logic [SAMPLE_BITS-1:0]            green_baseline,
	output logic                              led_write,
	output logic [ppgf_pkg::LED_W-1:0]        led_level,
	output logic                              enter_proximity,
	output logic                              resume_sampling,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ppgf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [SAMPLE_BITS-1:0]            cfg_data
);
	import ppgf_pkg::*;

	localparam int COEF_W = COEF_FRAC_BITS + 1;

	localparam logic [COEF_W-1:0] C_HP0 = COEF_W'(qcoef(HP_A0_U, COEF_FRAC_BITS));
	localparam logic [COEF_W-1:0] C_HP1 = COEF_W'(qcoef(HP_A1_U, COEF_FRAC_BITS));
	localparam logic [COEF_W-1:0] C_HP2 = COEF_W'(qcoef(HP_A2_U, COEF_FRAC_BITS));
	localparam logic [COEF_W-1:0] C_LP0 = COEF_W'(qcoef(LP_A0_U, COEF_FRAC_BITS));
	localparam logic [COEF_W-1:0] C_LP1 = COEF_W'(qcoef(LP_A1_U, COEF_FRAC_BITS));
	localparam logic [COEF_W-1:0] C_LP2 = COEF_W'(qcoef(LP_A2_U, COEF_FRAC_BITS));
	localparam logic [COEF_W-1:0] C_UL0 = COEF_W'(qcoef(UL_A0_U, COEF_FRAC_BITS));
	localparam logic [COEF_W-1:0] C_UL1 = COEF_W'(qcoef(UL_A1_U, COEF_FRAC_BITS));
	localparam logic [COEF_W-1:0] C_UL2 = COEF_W'(qcoef(UL_A2_U, COEF_FRAC_BITS));

	// Control and configuration.
	run_st_t              st_q;
	logic [UPC_W-1:0]     upc_q;
	logic [CH_W-1:0]      ch_q;
	kind_t                kind_q;
	logic                 prox_seen_q;
	logic [SAMPLE_BITS-1:0] last_ir_q;
	logic [MODE_W-1:0]    mode_q;
	logic [SAMPLE_BITS-1:0] high_q;
	logic [SAMPLE_BITS-1:0] low_q;
	logic [SAMPLE_BITS-1:0] off_q;
	logic [LED_W-1:0]     stby_q;
	logic [LED_W-1:0]     maxc_q;

	// Request payload.
	logic [SAMPLE_BITS-1:0] smp_q [NUM_CH];
	logic [LED_W-1:0]     amp_q;

	// Filter state per channel.
	logic [SAMPLE_BITS-1:0] hp_out_q  [NUM_CH];
	logic [SAMPLE_BITS-1:0] hp_prev_q [NUM_CH];
	logic [SAMPLE_BITS-1:0] lp_out_q  [NUM_CH];
	logic [SAMPLE_BITS-1:0] lp_prev_q [NUM_CH];
	logic [SAMPLE_BITS-1:0] ul_out_q  [NUM_CH];
	logic [SAMPLE_BITS-1:0] ul_prev_q [NUM_CH];

	// Output register.
	logic                 out_valid_q;
	logic                 status_q;
	logic [SAMPLE_BITS-1:0] band_q [NUM_CH];
	logic [SAMPLE_BITS-1:0] base_q [NUM_CH];
	logic                 led_write_q;
	logic [LED_W-1:0]     led_level_q;
	logic                 enter_prox_q;
	logic                 resume_q;

	ucw_t                 ucw;
	logic                 in_acc;
	logic                 more_ch;
	logic                 can_fin;
	logic                 fin;
	logic [SAMPLE_BITS-1:0] op_y;
	logic [SAMPLE_BITS-1:0] op_x;
	logic [SAMPLE_BITS-1:0] op_xp;
	logic [SAMPLE_BITS-1:0] opnd;
	logic [COEF_W-1:0]    coef;
	acc_op_t              mac_op;
	logic [SAMPLE_BITS-1:0] stg_res;
	logic [SAMPLE_BITS-1:0] calib;
	logic                 g_status;
	logic                 g_write;
	logic [LED_W-1:0]     g_level;
	logic                 g_enter;
	logic                 g_resume;

	assign ucw       = ucode(upc_q);
	assign in_stall  = (st_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign more_ch   = ((ch_q == CH_RED) && (mode_q != MODE_RED)) ||
		((ch_q == CH_IR) && (mode_q == MODE_ALL));
	assign can_fin   = !out_valid_q || !out_stall;
	assign fin       = (st_q == ST_RUN) && (ucw.br == BR_DONE) && can_fin;

	// Operands of the current stage for the current channel.
	always_comb begin
		case (ucw.stg)
			STG_LP: begin
				op_y  = lp_out_q[ch_q];
				op_x  = hp_out_q[ch_q];
				op_xp = lp_prev_q[ch_q];
			end
			STG_UL: begin
				op_y  = ul_out_q[ch_q];
				op_x  = lp_out_q[ch_q];
				op_xp = ul_prev_q[ch_q];
			end
			default: begin
				op_y  = hp_out_q[ch_q];
				op_x  = smp_q[ch_q];
				op_xp = hp_prev_q[ch_q];
			end
		endcase
		case (ucw.opnd)
			OPND_X:  opnd = op_x;
			OPND_XP: opnd = op_xp;
			default: opnd = op_y;
		endcase
		case ({ucw.stg, ucw.cix})
			{STG_HP, 2'd0}: coef = C_HP0;
			{STG_HP, 2'd1}: coef = C_HP1;
			{STG_HP, 2'd2}: coef = C_HP2;
			{STG_LP, 2'd0}: coef = C_LP0;
			{STG_LP, 2'd1}: coef = C_LP1;
			{STG_LP, 2'd2}: coef = C_LP2;
			{STG_UL, 2'd0}: coef = C_UL0;
			{STG_UL, 2'd1}: coef = C_UL1;
			{STG_UL, 2'd2}: coef = C_UL2;
			default:        coef = '0;
		endcase
	end

	assign mac_op = (st_q == ST_RUN) ? ucw.acc_op : ACC_NOP;

	ppgf_mac #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.opnd   (opnd),
		.coef   (coef),
		.acc_op (mac_op),
		.result (stg_res)
	);

	// Gain decision on the raw calibration sample of the event.
	always_comb begin
		calib    = (mode_q != MODE_RED) ? smp_q[CH_IR] : smp_q[CH_RED];
		g_status = 1'b0;
		g_write  = 1'b0;
		g_level  = '0;
		g_enter  = 1'b0;
		g_resume = 1'b0;
		case (kind_q)
			KIND_PROX: begin
				g_resume = 1'b1;
				g_status = 1'b1;
			end
			KIND_DATA: begin
				if (calib >= high_q) begin
					g_status = 1'b1;
					if (amp_q > stby_q) begin
						g_write = 1'b1;
						g_level = amp_q - LED_W'(1);
					end
				end else if (calib <= low_q) begin
					g_status = 1'b1;
					if (maxc_q > amp_q) begin
						g_write = 1'b1;
						g_level = amp_q + LED_W'(1);
					end else if ((last_ir_q <= off_q) && prox_seen_q) begin
						g_write = 1'b1;
						g_level = stby_q;
						g_enter = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			upc_q       <= '0;
			ch_q        <= CH_RED;
			kind_q      <= KIND_NONE;
			prox_seen_q <= 1'b0;
			last_ir_q   <= '0;
			mode_q      <= MODE_RED;
			high_q      <= '1;
			low_q       <= '0;
			off_q       <= '0;
			stby_q      <= '0;
			maxc_q      <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE: mode_q <= cfg_data[MODE_W-1:0];
					REG_HIGH: high_q <= cfg_data;
					REG_LOW:  low_q  <= cfg_data;
					REG_OFF:  off_q  <= cfg_data;
					REG_STBY: stby_q <= cfg_data[LED_W-1:0];
					REG_MAXC: maxc_q <= cfg_data[LED_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_valid_q && !out_stall && !fin) begin
				out_valid_q <= 1'b0;
			end

			if (in_acc) begin
				st_q <= ST_RUN;
				ch_q <= CH_RED;
				if (prox_event) begin
					kind_q <= KIND_PROX;
					upc_q  <= FIN_PC;
				end else if (data_ready) begin
					kind_q <= KIND_DATA;
					upc_q  <= '0;
					if (mode_q != MODE_RED) begin
						last_ir_q <= ir_sample;
					end
				end else begin
					kind_q <= KIND_NONE;
					upc_q  <= FIN_PC;
				end
			end else if (st_q == ST_RUN) begin
				case (ucw.br)
					BR_CHAN: begin
						if (more_ch) begin
							ch_q  <= ch_q + CH_W'(1);
							upc_q <= '0;
						end else begin
							upc_q <= upc_q + UPC_W'(1);
						end
					end
					BR_DONE: begin
						if (can_fin) begin
							st_q        <= ST_IDLE;
							upc_q       <= '0;
							out_valid_q <= 1'b1;
							case (kind_q)
								KIND_PROX: prox_seen_q <= 1'b0;
								KIND_DATA: prox_seen_q <= 1'b1;
								default: begin
								end
							endcase
						end
					end
					default: upc_q <= upc_q + UPC_W'(1);
				endcase
			end
		end
	end

	// Filter state write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				hp_out_q[i]  <= '0;
				hp_prev_q[i] <= '0;
				lp_out_q[i]  <= '0;
				lp_prev_q[i] <= '0;
				ul_out_q[i]  <= '0;
				ul_prev_q[i] <= '0;
			end
		end else if ((st_q == ST_RUN) && ucw.wb) begin
			case (ucw.stg)
				STG_LP: begin
					lp_out_q[ch_q]  <= stg_res;
					lp_prev_q[ch_q] <= hp_out_q[ch_q];
				end
				STG_UL: begin
					ul_out_q[ch_q]  <= stg_res;
					ul_prev_q[ch_q] <= lp_out_q[ch_q];
				end
				default: begin
					hp_out_q[ch_q]  <= stg_res;
					hp_prev_q[ch_q] <= smp_q[ch_q];
				end
			endcase
		end
	end

	// Payload and result registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_q[CH_RED]   <= red_sample;
			smp_q[CH_IR]    <= ir_sample;
			smp_q[CH_GREEN] <= green_sample;
			amp_q           <= led_amplitude;
		end
		if (fin) begin
			status_q     <= g_status;
			led_write_q  <= g_write;
			led_level_q  <= g_level;
			enter_prox_q <= g_enter;
			resume_q     <= g_resume;
			for (int i = 0; i < NUM_CH; i++) begin
				band_q[i] <= lp_out_q[i];
				base_q[i] <= ul_out_q[i];
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign red_band        = band_q[CH_RED];
	assign red_baseline    = base_q[CH_RED];
	assign ir_band         = band_q[CH_IR];
	assign ir_baseline     = base_q[CH_IR];
	assign green_band      = band_q[CH_GREEN];
	assign green_baseline  = base_q[CH_GREEN];
	assign led_write       = led_write_q;
	assign led_level       = led_level_q;
	assign enter_proximity = enter_prox_q;
	assign resume_sampling = resume_q;

	a_enter_writes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && enter_proximity |-> led_write && status)
		else $error("proximity fallback without LED write");

	a_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !led_write |-> led_level == '0)
		else $error("LED level set without a write");

	a_resume_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && resume_sampling |-> status && !led_write && !enter_proximity)
		else $error("proximity result carries gain requests");

	a_data_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !prox_event && data_ready |=> st_q == ST_RUN && upc_q == '0 &&
		ch_q == CH_RED)
		else $error("data request did not start the program on the red channel");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RUN |-> ch_q != 2'd3)
		else $error("channel index out of range");

endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the PPG filter cascade and LED automatic gain block.
`default_nettype none
module tb;
	import ppgf_pkg::*;

	localparam int SW = SAMPLE_BITS_DEF;
	localparam int FRAC = COEF_FRAC_DEF;
	localparam logic [SW-1:0] SMAX = {SW{1'b1}};
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 60;

	typedef struct packed {
		logic            prox;
		logic            ready;
		logic [SW-1:0]   red;
		logic [SW-1:0]   ir;
		logic [SW-1:0]   green;
		logic [LED_W-1:0] amp;
	} sensor_evt_t;

	typedef struct packed {
		logic            status;
		logic [SW-1:0]   red_band;
		logic [SW-1:0]   red_base;
		logic [SW-1:0]   ir_band;
		logic [SW-1:0]   ir_base;
		logic [SW-1:0]   green_band;
		logic [SW-1:0]   green_base;
		logic            led_write;
		logic [LED_W-1:0] led_level;
		logic            enter_prox;
		logic            resume;
	} ppg_result_t;

	typedef struct {
		logic        is_cfg;
		cfg_reg_t    idx;
		logic [SW-1:0] value;
		sensor_evt_t ev;
		logic        known;
		ppg_result_t want;
	} plan_row_t;

	// Coefficient c held as round(c * 2^FRAC), from a value in millionths.
	function automatic longint to_q(longint micro);
		return (micro * (64'sd1 <<< FRAC) * 2 + 64'sd1000000) / 64'sd2000000;
	endfunction

	localparam longint HP0 = to_q(881600);
	localparam longint HP1 = to_q(940800);
	localparam longint HP2 = -to_q(940800);
	localparam longint LP0 = to_q(591400);
	localparam longint LP1 = to_q(204300);
	localparam longint LP2 = to_q(204300);
	localparam longint UL0 = to_q(987500);
	localparam longint UL1 = to_q(6244);
	localparam longint UL2 = to_q(6244);

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic prox_event;
	logic data_ready;
	logic [SW-1:0] red_sample;
	logic [SW-1:0] ir_sample;
	logic [SW-1:0] green_sample;
	logic [LED_W-1:0] led_amplitude;
	logic out_valid;
	logic out_stall = 1'b0;
	logic status;
	logic [SW-1:0] red_band;
	logic [SW-1:0] red_baseline;
	logic [SW-1:0] ir_band;
	logic [SW-1:0] ir_baseline;
	logic [SW-1:0] green_band;
	logic [SW-1:0] green_baseline;
	logic led_write;
	logic [LED_W-1:0] led_level;
	logic enter_proximity;
	logic resume_sampling;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SW-1:0] cfg_data;

	// Filter state of the predictor, per channel.
	logic [SW-1:0] hp_y [NUM_CH];
	logic [SW-1:0] hp_xp [NUM_CH];
	logic [SW-1:0] lp_y [NUM_CH];
	logic [SW-1:0] lp_xp [NUM_CH];
	logic [SW-1:0] ul_y [NUM_CH];
	logic [SW-1:0] ul_xp [NUM_CH];
	logic prox_armed = 1'b0;
	logic [SW-1:0] ir_held = '0;

	// Register copies, at their reset values.
	logic [MODE_W-1:0] mode_q = MODE_RED;
	logic [SW-1:0] high_q = SMAX;
	logic [SW-1:0] low_q = '0;
	logic [SW-1:0] off_q = '0;
	logic [LED_W-1:0] stby_q = '0;
	logic [LED_W-1:0] maxc_q = '1;

	ppg_result_t expected_q[$];
	plan_row_t plan[$];
	int errors = 0;
	bit quiet = 1'b0;
	int stall_left = 0;

	ppg_filter_and_led_gain i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.prox_event(prox_event),
		.data_ready(data_ready),
		.red_sample(red_sample),
		.ir_sample(ir_sample),
		.green_sample(green_sample),
		.led_amplitude(led_amplitude),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.red_band(red_band),
		.red_baseline(red_baseline),
		.ir_band(ir_band),
		.ir_baseline(ir_baseline),
		.green_band(green_band),
		.green_baseline(green_baseline),
		.led_write(led_write),
		.led_level(led_level),
		.enter_proximity(enter_proximity),
		.resume_sampling(resume_sampling),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

	// One first-order section: a0*y + a1*x + a2*xp, truncated, clamped at both ends.
	function automatic logic [SW-1:0] iir_stage(longint a0, longint a1, longint a2,
		logic [SW-1:0] y, logic [SW-1:0] x, logic [SW-1:0] xp);
		longint acc;
		acc = a0 * longint'({40'd0, y}) + a1 * longint'({40'd0, x})
			+ a2 * longint'({40'd0, xp});
		if (acc < 0)
			return '0;
		acc = acc >>> FRAC;
		if (acc > longint'({40'd0, SMAX}))
			return SMAX;
		return acc[SW-1:0];
	endfunction

	task automatic filter_channel(int ch, logic [SW-1:0] x);
		logic [SW-1:0] h, l, u;
		h = iir_stage(HP0, HP1, HP2, hp_y[ch], x, hp_xp[ch]);
		l = iir_stage(LP0, LP1, LP2, lp_y[ch], h, lp_xp[ch]);
		u = iir_stage(UL0, UL1, UL2, ul_y[ch], l, ul_xp[ch]);
		hp_y[ch] = h;
		hp_xp[ch] = x;
		lp_y[ch] = l;
		lp_xp[ch] = h;
		ul_y[ch] = u;
		ul_xp[ch] = l;
	endtask

	task automatic predict_event(input sensor_evt_t ev, output ppg_result_t r);
		logic [SW-1:0] calib;
		r = '0;
		if (ev.prox) begin
			r.resume = 1'b1;
			r.status = 1'b1;
			prox_armed = 1'b0;
		end else if (ev.ready) begin
			calib = ev.red;
			filter_channel(CH_RED, ev.red);
			if (mode_q >= MODE_RED_IR) begin
				filter_channel(CH_IR, ev.ir);
				ir_held = ev.ir;
				calib = ev.ir;
			end
			if (mode_q == MODE_ALL)
				filter_channel(CH_GREEN, ev.green);
			if (calib >= high_q) begin
				if (ev.amp > stby_q) begin
					r.led_write = 1'b1;
					r.led_level = ev.amp - 1'b1;
				end
				r.status = 1'b1;
			end else if (calib <= low_q) begin
				if (maxc_q > ev.amp) begin
					r.led_write = 1'b1;
					r.led_level = ev.amp + 1'b1;
				end else if (ir_held <= off_q && prox_armed) begin
					// Weak signal with nothing in front of the sensor: drop to standby.
					r.led_write = 1'b1;
					r.led_level = stby_q;
					r.enter_prox = 1'b1;
				end
				r.status = 1'b1;
			end
			prox_armed = 1'b1;
		end
		r.red_band = lp_y[CH_RED];
		r.red_base = ul_y[CH_RED];
		r.ir_band = lp_y[CH_IR];
		r.ir_base = ul_y[CH_IR];
		r.green_band = lp_y[CH_GREEN];
		r.green_base = ul_y[CH_GREEN];
	endtask

	task automatic send_event(sensor_evt_t ev, logic known, ppg_result_t want);
		ppg_result_t r;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		prox_event <= ev.prox;
		data_ready <= ev.ready;
		red_sample <= ev.red;
		ir_sample <= ev.ir;
		green_sample <= ev.green;
		led_amplitude <= ev.amp;
		do @(posedge clk); while (in_stall);
		predict_event(ev, r);
		expected_q.push_back(known ? want : r);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [SW-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE: mode_q = v[MODE_W-1:0];
			REG_HIGH: high_q = v;
			REG_LOW:  low_q = v;
			REG_OFF:  off_q = v;
			REG_STBY: stby_q = v[LED_W-1:0];
			REG_MAXC: maxc_q = v[LED_W-1:0];
			default: ;
		endcase
	endtask

	task automatic add_cfg(cfg_reg_t idx, logic [SW-1:0] v);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.value = v;
		row.ev = '0;
		row.known = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endtask

	task automatic add_ev(logic p, logic rdy, logic [SW-1:0] red, logic [SW-1:0] ir,
		logic [SW-1:0] green, logic [LED_W-1:0] amp);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.idx = REG_MODE;
		row.value = '0;
		row.ev = {p, rdy, red, ir, green, amp};
		row.known = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endtask

	// Rows whose result is plain from zero filter state: bands all zero.
	task automatic add_known(logic p, logic rdy, logic [SW-1:0] red, logic [SW-1:0] ir,
		logic [SW-1:0] green, logic [LED_W-1:0] amp, logic st, logic wr,
		logic [LED_W-1:0] lvl, logic res);
		add_ev(p, rdy, red, ir, green, amp);
		plan[$].known = 1'b1;
		plan[$].want.status = st;
		plan[$].want.led_write = wr;
		plan[$].want.led_level = lvl;
		plan[$].want.resume = res;
	endtask

	function automatic logic [SW-1:0] pick_sample();
		case ($urandom_range(0, 3))
			0: return SW'($urandom_range(0, int'(low_q)));
			1: return SW'($urandom_range(int'(high_q), int'(SMAX)));
			2: return SW'($urandom);
			default: return $urandom_range(0, 1) ? SMAX : '0;
		endcase
	endfunction

	task automatic setup_phase(int p);
		logic [SW-1:0] hi, lo, off;
		logic [LED_W-1:0] sb, mx;
		if (p == 0) begin
			hi = '0;
			lo = SMAX;
			off = SMAX;
			sb = '0;
			mx = '1;
		end else if (p == 1) begin
			hi = SMAX;
			lo = '0;
			off = '0;
			sb = '1;
			mx = '0;
		end else begin
			hi = SW'($urandom_range(24'hA00000, 24'hFFFFFF));
			lo = SW'($urandom_range(0, 24'h600000));
			off = SW'($urandom_range(0, 24'h800000));
			sb = LED_W'($urandom_range(0, 40));
			mx = LED_W'($urandom_range(200, 255));
		end
		write_reg(REG_MODE, SW'(p % 4));
		write_reg(REG_HIGH, hi);
		write_reg(REG_LOW, lo);
		write_reg(REG_OFF, off);
		write_reg(REG_STBY, SW'(sb));
		write_reg(REG_MAXC, SW'(mx));
		cfg_valid <= 1'b0;
	endtask

	// Output side: random stall bursts, which start only outside the quiet phases.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 5);
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic void check_field(string name, longint got, longint want);
		if (got != want) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		ppg_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result with no request pending, expected none actual status %0h",
					$time, status);
				errors++;
			end else begin
				want = expected_q.pop_front();
				check_field("status", status, want.status);
				check_field("red_band", red_band, want.red_band);
				check_field("red_baseline", red_baseline, want.red_base);
				check_field("ir_band", ir_band, want.ir_band);
				check_field("ir_baseline", ir_baseline, want.ir_base);
				check_field("green_band", green_band, want.green_band);
				check_field("green_baseline", green_baseline, want.green_base);
				check_field("led_write", led_write, want.led_write);
				check_field("led_level", led_level, want.led_level);
				check_field("enter_proximity", enter_proximity, want.enter_prox);
				check_field("resume_sampling", resume_sampling, want.resume);
			end
		end
	end

	initial begin
		sensor_evt_t ev;
		int kind;
		for (int c = 0; c < NUM_CH; c++) begin
			hp_y[c] = '0;
			hp_xp[c] = '0;
			lp_y[c] = '0;
			lp_xp[c] = '0;
			ul_y[c] = '0;
			ul_xp[c] = '0;
		end
		arst_n = 1'b0;
		in_valid = 1'b0;
		prox_event = 1'b0;
		data_ready = 1'b0;
		red_sample = '0;
		ir_sample = '0;
		green_sample = '0;
		led_amplitude = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		// Directed part. Opening rows run from zero filter state at reset settings.
		add_known(1'b0, 1'b0, SMAX, SMAX, SMAX, '1, 1'b0, 1'b0, '0, 1'b0);
		add_known(1'b1, 1'b0, '0, '0, '0, '0, 1'b1, 1'b0, '0, 1'b1);
		// Both flags: the proximity event wins and the data is dropped.
		add_known(1'b1, 1'b1, SMAX, SMAX, SMAX, '1, 1'b1, 1'b0, '0, 1'b1);
		add_known(1'b0, 1'b1, '0, SMAX, SMAX, '0, 1'b1, 1'b1, 8'd1, 1'b0);
		add_ev(1'b0, 1'b1, SMAX, '0, '0, 8'hFF);
		add_ev(1'b0, 1'b1, SMAX, '0, '0, 8'h00);
		// Amplitude at the ceiling, infrared held at zero: fall back to proximity.
		add_ev(1'b0, 1'b1, '0, SMAX, '0, 8'hFF);
		add_ev(1'b1, 1'b0, '0, '0, '0, 8'h00);
		add_ev(1'b0, 1'b1, '0, '0, '0, 8'hFF);
		add_ev(1'b0, 1'b1, 24'h800000, 24'h7FFFFF, 24'h555555, 8'h80);
		add_cfg(REG_MODE, SW'(MODE_RED_IR));
		add_cfg(REG_HIGH, 24'h900000);
		add_cfg(REG_LOW, 24'h100000);
		add_cfg(REG_OFF, 24'h200000);
		add_cfg(REG_STBY, 24'h10);
		add_cfg(REG_MAXC, 24'h80);
		add_ev(1'b0, 1'b1, '0, 24'hA00000, '0, 8'h40);
		add_ev(1'b0, 1'b1, SMAX, 24'h050000, '0, 8'h80);
		add_ev(1'b0, 1'b1, '0, 24'h300000, '0, 8'h10);
		add_ev(1'b0, 1'b1, '0, SMAX, '0, 8'h10);
		add_cfg(REG_MODE, SW'(MODE_ALL));
		add_ev(1'b0, 1'b1, SMAX, SMAX, SMAX, 8'hFF);
		add_ev(1'b0, 1'b1, '0, '0, '0, 8'h00);
		// Mode value three filters red and infrared only.
		add_cfg(REG_MODE, 24'd3);
		add_ev(1'b0, 1'b1, 24'h123456, 24'h000001, SMAX, 8'h7F);
		add_cfg(REG_MODE, SW'(MODE_RED));
		add_cfg(REG_STBY, 24'hFF);
		add_cfg(REG_MAXC, 24'h00);
		add_ev(1'b0, 1'b1, SMAX, 24'h0F0F0F, 24'hF0F0F0, 8'hFF);
		add_ev(1'b0, 1'b1, '0, '0, '0, 8'h00);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				wait_drained();
				write_reg(plan[i].idx, plan[i].value);
			end else begin
				cfg_valid <= 1'b0;
				send_event(plan[i].ev, plan[i].known, plan[i].want);
			end
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			wait_drained();
			quiet = (p == 3 || p == RAND_PHASES - 1);
			setup_phase(p);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				kind = $urandom_range(0, 19);
				ev.prox = (kind <= 2);
				ev.ready = (kind >= 2 && kind != 3);
				ev.red = pick_sample();
				ev.ir = pick_sample();
				ev.green = pick_sample();
				case ($urandom_range(0, 3))
					0: ev.amp = stby_q;
					1: ev.amp = maxc_q;
					default: ev.amp = LED_W'($urandom);
				endcase
				send_event(ev, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (60) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
rtl/core/ppgf_pkg.sv
rtl/core/ppgf_mac.sv
rtl/core/ppg_filter_and_led_gain.sv
dv/tb.sv
